### src/two_key_press_page_navigator_unit_assert.svh
// Assertion macros for the checker file
`ifndef TWO_KEY_PRESS_PAGE_NAVIGATOR_UNIT_ASSERT_SVH
`define TWO_KEY_PRESS_PAGE_NAVIGATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TKPN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TKPN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tkpn_pkg.sv
`default_nettype none
package tkpn_pkg;

  // Width of the wrapping millisecond clock
  localparam int TIME_BITS = 32;

  // Key events
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // Result actions
  localparam logic [1:0] ACT_PRINT = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_CONFIRM   = 2'd0;
  localparam logic [1:0] REG_SHORT_MAX = 2'd1;
  localparam logic [1:0] REG_LONG      = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [15:0] confirm_ms;
    logic [15:0] short_max_ms;
    logic [15:0] long_ms;
  } tkpn_cfg_t;

  // One classified sample: events of both keys plus the number of pages
  typedef struct packed {
    logic [1:0]  ev1;
    logic [1:0]  ev2;
    logic [15:0] num_pages;
  } tkpn_evt_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] shown_page;
    logic        viewer_on;
    logic        last;
  } tkpn_res_t;

endpackage
`default_nettype wire

### src/tkpn_in_if.sv
`default_nettype none
interface tkpn_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        key1_pressed;
  logic        key2_pressed;
  logic [15:0] num_pages;

  modport source (
    output valid, now_ms, key1_pressed, key2_pressed, num_pages,
    input  ready
  );
  modport sink (
    input  valid, now_ms, key1_pressed, key2_pressed, num_pages,
    output ready
  );
endinterface
`default_nettype wire

### src/tkpn_out_if.sv
`default_nettype none
interface tkpn_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] shown_page;
  logic        viewer_on;
  logic        last;

  modport source (
    output valid, action, shown_page, viewer_on, last,
    input  ready
  );
  modport sink (
    input  valid, action, shown_page, viewer_on, last,
    output ready
  );
endinterface
`default_nettype wire

### src/two_key_press_page_navigator_unit.sv
// A sample accepted on in_ch is queued, popped into the back end's pending list, then moved
// to the output register that drives out_ch. One sample per cycle enters while the queue has room;
// one action per cycle leaves while out_ch is ready, up to three per sample (quiet: none).
// A four-entry event queue sits between the key front end and the viewer back end.
// Reset (rst_n low, synchronous): keys released at time 0, viewer off, page 0,
// registers confirm_ms=20, short_max_ms=800, long_ms=2000.
`default_nettype none
module two_key_press_page_navigator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tkpn_in_if.sink          in_ch,
  tkpn_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tkpn_pkg::*;

  tkpn_cfg_t cfg_r;
  logic      wr_en;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  tkpn_evt_t q_wdata;
  tkpn_evt_t q_rdata;
  tkpn_res_t res;
  logic      res_valid;

  // Register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_ms   <= 16'd20;
      cfg_r.short_max_ms <= 16'd800;
      cfg_r.long_ms      <= 16'd2000;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CONFIRM:   cfg_r.confirm_ms   <= pwdata[15:0];
        REG_SHORT_MAX: cfg_r.short_max_ms <= pwdata[15:0];
        REG_LONG:      cfg_r.long_ms      <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CONFIRM:   prdata = {16'd0, cfg_r.confirm_ms};
      REG_SHORT_MAX: prdata = {16'd0, cfg_r.short_max_ms};
      REG_LONG:      prdata = {16'd0, cfg_r.long_ms};
      default:       prdata = 32'd0;
    endcase
  end

  tkpn_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  tkpn_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_data   (q_rdata)
  );

  tkpn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (res_valid),
    .out_data  (res),
    .out_ready (out_ch.ready)
  );

  // Drive the result channel
  assign out_ch.valid      = res_valid;
  assign out_ch.action     = res.action;
  assign out_ch.shown_page = res.shown_page;
  assign out_ch.viewer_on  = res.viewer_on;
  assign out_ch.last       = res.last;

endmodule
`default_nettype wire

### src/tkpn_key.sv
`default_nettype none
module tkpn_key (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              step,
  input  wire logic                              raw,
  input  wire logic [tkpn_pkg::TIME_BITS-1:0]    now,
  input  wire tkpn_pkg::tkpn_cfg_t               cfg,
  output logic [1:0]                             ev
);
  import tkpn_pkg::*;

  logic                 stable_r, stable_nxt;
  logic                 prev_r, prev_nxt;
  logic                 fired_r, fired_nxt;
  logic [TIME_BITS-1:0] chg_r, chg_nxt;
  logic [TIME_BITS-1:0] press_r, press_nxt;

  logic [TIME_BITS-1:0] d_chg;
  logic [TIME_BITS-1:0] d_press;
  logic [TIME_BITS-1:0] el_press;
  logic                 changed;
  logic                 confirmed;

  // Elapsed times against the stored marks, wrapping
  assign d_chg   = now - chg_r;
  assign d_press = now - press_r;
  assign changed = raw != prev_r;

  // A fresh raw edge restarts the confirm window at zero
  assign confirmed = changed ? (cfg.confirm_ms == 16'd0)
                             : (d_chg >= TIME_BITS'(cfg.confirm_ms));

  // Debounce, then classify release and hold
  always_comb begin
    stable_nxt = stable_r;
    prev_nxt   = raw;
    fired_nxt  = fired_r;
    chg_nxt    = changed ? now : chg_r;
    press_nxt  = press_r;
    el_press   = d_press;
    ev         = EV_NONE;
    if (confirmed) begin
      if (raw != stable_r) begin
        stable_nxt = raw;
        if (raw) begin
          press_nxt = now;
          el_press  = '0;
          fired_nxt = 1'b0;
        end else begin
          if (!fired_r && d_press <= TIME_BITS'(cfg.short_max_ms)) begin
            ev = EV_SHORT;
          end
          fired_nxt = 1'b0;
        end
      end
      if (stable_nxt && !fired_nxt && el_press >= TIME_BITS'(cfg.long_ms)) begin
        fired_nxt = 1'b1;
        ev        = EV_LONG;
      end
    end
  end

  // Commit key state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      prev_r   <= 1'b0;
      fired_r  <= 1'b0;
      chg_r    <= '0;
      press_r  <= '0;
    end else if (step) begin
      stable_r <= stable_nxt;
      prev_r   <= prev_nxt;
      fired_r  <= fired_nxt;
      chg_r    <= chg_nxt;
      press_r  <= press_nxt;
    end
  end

endmodule
`default_nettype wire

### src/tkpn_front.sv
`default_nettype none
module tkpn_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tkpn_pkg::tkpn_cfg_t  cfg,
  tkpn_in_if.sink                   in_ch,
  input  wire logic                 q_full,
  output logic                      q_push,
  output tkpn_pkg::tkpn_evt_t       q_data
);
  import tkpn_pkg::*;

  logic [1:0] ev1;
  logic [1:0] ev2;
  logic       step;

  // Accept whenever the event queue has room
  assign in_ch.ready = !q_full;
  assign step        = in_ch.valid && !q_full;

  tkpn_key u_key1 (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .raw   (in_ch.key1_pressed),
    .now   (in_ch.now_ms[TIME_BITS-1:0]),
    .cfg   (cfg),
    .ev    (ev1)
  );

  tkpn_key u_key2 (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .raw   (in_ch.key2_pressed),
    .now   (in_ch.now_ms[TIME_BITS-1:0]),
    .cfg   (cfg),
    .ev    (ev2)
  );

  // Queue every sample, quiet ones too, so order is kept
  assign q_push           = step;
  assign q_data.ev1       = ev1;
  assign q_data.ev2       = ev2;
  assign q_data.num_pages = in_ch.num_pages;

endmodule
`default_nettype wire

### src/tkpn_fifo.sv
`default_nettype none
module tkpn_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tkpn_pkg::tkpn_evt_t  wr_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      not_empty,
  output tkpn_pkg::tkpn_evt_t       rd_data
);
  import tkpn_pkg::*;

  tkpn_evt_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full      = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign not_empty = cnt_r != '0;
  assign rd_data   = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/tkpn_back.sv
`default_nettype none
module tkpn_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire tkpn_pkg::tkpn_evt_t  q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  output tkpn_pkg::tkpn_res_t       out_data,
  input  wire logic                 out_ready
);
  import tkpn_pkg::*;

  logic        viewer_r;
  logic [15:0] page_r;
  tkpn_res_t   pend_r [3];
  logic [1:0]  left_r;
  logic [1:0]  idx_r;
  logic        out_valid_r;
  tkpn_res_t   out_r;

  tkpn_res_t   acts [3];
  logic [1:0]  n;
  logic        va;
  logic [15:0] pg;
  logic        move;

  function automatic logic [15:0] clamp_page(input logic [15:0] p, input logic [15:0] c);
    logic [15:0] r;
    r = p;
    if (p >= c) begin
      r = (c == 16'd0) ? 16'd0 : c - 16'd1;
    end
    return r;
  endfunction

  // Build the action list of one sample: key 1 first, then key 2
  always_comb begin
    va = viewer_r;
    pg = page_r;
    n  = 2'd0;
    for (int k = 0; k < 3; k++) begin
      acts[k] = '0;
    end
    case (q_data.ev1)
      EV_SHORT: begin
        if (!va) begin
          va = 1'b1;
          pg = 16'd0;
        end else if (pg != 16'd0) begin
          pg = pg - 16'd1;
        end
        pg = clamp_page(pg, q_data.num_pages);
        acts[n] = '{action: ACT_PRINT, shown_page: pg, viewer_on: va, last: 1'b0};
        n = n + 2'd1;
      end
      EV_LONG: begin
        va = 1'b0;
        acts[n] = '{action: ACT_STOP, shown_page: 16'd0, viewer_on: 1'b0, last: 1'b0};
        n = n + 2'd1;
      end
      default: begin
      end
    endcase
    case (q_data.ev2)
      EV_SHORT: begin
        if (va) begin
          if ({1'b0, pg} + 17'd1 < {1'b0, q_data.num_pages}) begin
            pg = pg + 16'd1;
          end
          pg = clamp_page(pg, q_data.num_pages);
          acts[n] = '{action: ACT_PRINT, shown_page: pg, viewer_on: va, last: 1'b0};
          n = n + 2'd1;
        end
      end
      EV_LONG: begin
        va = 1'b1;
        pg = 16'd0;
        acts[n] = '{action: ACT_CLEAR, shown_page: 16'd0, viewer_on: 1'b1, last: 1'b0};
        n = n + 2'd1;
        pg = clamp_page(pg, q_data.num_pages);
        acts[n] = '{action: ACT_PRINT, shown_page: pg, viewer_on: va, last: 1'b0};
        n = n + 2'd1;
      end
      default: begin
      end
    endcase
    if (n != 2'd0) begin
      acts[n - 2'd1].last = 1'b1;
    end
  end

  // Move a pending action whenever the output register frees up
  assign move  = (left_r != 2'd0) && (!out_valid_r || out_ready);
  assign q_pop = q_valid && ((left_r == 2'd0) || (left_r == 2'd1 && move));

  // Viewer state and pending list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viewer_r <= 1'b0;
      page_r   <= 16'd0;
      left_r   <= 2'd0;
      idx_r    <= 2'd0;
    end else if (q_pop) begin
      viewer_r <= va;
      page_r   <= pg;
      left_r   <= n;
      idx_r    <= 2'd0;
    end else if (move) begin
      left_r <= left_r - 2'd1;
      idx_r  <= idx_r + 2'd1;
    end
  end

  // Hold the action list of the popped sample
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < 3; k++) begin
        pend_r[k] <= acts[k];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= pend_r[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### src/tkpn_checker.sv
`default_nettype none
`include "two_key_press_page_navigator_unit_assert.svh"
module tkpn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  action,
  input wire logic [15:0] shown_page,
  input wire logic        viewer_on,
  input wire logic        last
);
  import tkpn_pkg::*;

  // A stalled transaction holds
  `TKPN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({action, shown_page, viewer_on, last}), "stalled result changed")
  // Stop and clear carry page zero
  `TKPN_ASSERT_NOW(a_page_zero, clk, rst_n, out_valid && action != ACT_PRINT, shown_page == 16'd0, "non-print result with a page")
  // Stop turns the viewer off
  `TKPN_ASSERT_NOW(a_stop_off, clk, rst_n, out_valid && action == ACT_STOP, !viewer_on, "stop with viewer on")
  // A clear is always followed by a print of the same sample
  `TKPN_ASSERT_NOW(a_clear_not_last, clk, rst_n, out_valid && action == ACT_CLEAR, viewer_on && !last, "clear closed a sample")

endmodule

bind two_key_press_page_navigator_unit tkpn_checker u_tkpn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .action     (out_ch.action),
  .shown_page (out_ch.shown_page),
  .viewer_on  (out_ch.viewer_on),
  .last       (out_ch.last)
);
`default_nettype wire
